// ===== hdl/qpvt_pkg.sv =====
// Package for the QUIC path validation table.
// Holds the command and result word types, operation codes and register map.
// No dependencies.
`default_nettype none
package qpvt_pkg;

  typedef enum logic [2:0] {
    OpSend     = 3'd0,
    OpResponse = 3'd1,
    OpConfirm  = 3'd2,
    OpAbandon  = 3'd3,
    OpRevert   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StCmp  = 3'b100
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  path_index;
    logic [63:0] challenge_value;
    logic [63:0] time_now;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] active_path;
  } res_t;

  typedef struct packed {
    logic [63:0] chal;
    logic [63:0] sent;
  } entry_t;

  localparam logic RegProbeTimeout = 1'b0;
  localparam logic [31:0] ProbeTimeoutRst = 32'd1000;
  localparam logic [33:0] ThreshRst = 34'd3000;

endpackage
`default_nettype wire

// ===== hdl/quic_path_validation_table_top.sv =====
// QUIC path validation table: per-path challenge memory, flags and active index.
// Each command passes through read, execute/write back and compare before its result
// strobe; busy holds off a new command until the compare step of the previous one.
// The receiver cannot stall; results are strobed for one cycle on done_o.
// Reset clears flags, entry valid bits, active index and sets probe_timeout to 1000.
// Depends on qpvt_pkg.
`default_nettype none
module quic_path_validation_table_top
  import qpvt_pkg::*;
#(
  parameter int PATHS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire cmd_t        cmd_i,
  output logic             done_o,
  output res_t             result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int IW = (AW > 2) ? AW : 2;
  localparam logic [IW:0] PathsW = (IW + 1)'(PATHS);

  state_e state_q, state_d;
  cmd_t cmd_q;
  logic [AW-1:0] addr_q;
  logic rng_q;
  entry_t mem [PATHS];
  entry_t rd_q;
  logic rd_vld_q;
  logic [PATHS-1:0] ent_vld_q, validated_q, confirmed_q;
  logic [1:0] active_q;
  logic [31:0] pto_q;
  logic [33:0] thr_q;
  logic [63:0] elapsed_q;
  logic cand_q, okpre_q;
  logic cand_d, okpre_d;
  logic done_q;
  res_t res_q;

  logic accept, in_rng, cfg_wr;
  logic [IW-1:0] idx_full;
  logic [AW-1:0] in_addr;
  logic [63:0] chal, sent;
  logic ok_now;

  assign accept   = start & ~busy;
  assign idx_full = IW'(cmd_i.path_index);
  assign in_addr  = idx_full[AW-1:0];
  assign in_rng   = {1'b0, idx_full} < PathsW;
  assign busy     = (state_q != StIdle);
  assign chal     = rd_vld_q ? rd_q.chal : 64'd0;
  assign sent     = rd_vld_q ? rd_q.sent : 64'd0;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == RegProbeTimeout);
  assign prdata = (paddr[2] == RegProbeTimeout) ? pto_q : 32'd0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StExec;
      StExec: state_d = StCmp;
      StCmp:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pto_q   <= ProbeTimeoutRst;
      thr_q   <= ThreshRst;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        pto_q <= pwdata;
        thr_q <= {2'b00, pwdata} + {1'b0, pwdata, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      addr_q <= in_addr;
      rng_q  <= in_rng;
      if (in_rng) begin
        rd_q <= mem[in_addr];
      end
    end
    if ((state_q == StExec) && rng_q) begin
      if (cmd_q.operation == OpSend) begin
        mem[addr_q] <= '{chal: cmd_q.challenge_value, sent: cmd_q.time_now};
      end else if ((cmd_q.operation == OpRevert) && (chal != 64'd0)) begin
        mem[addr_q] <= '{chal: 64'd0, sent: 64'd0};
      end
    end
    if (state_q == StExec) begin
      elapsed_q <= cmd_q.time_now - sent;
    end
  end

  always_comb begin
    okpre_d = 1'b0;
    cand_d  = 1'b0;
    if (rng_q) begin
      case (op_e'(cmd_q.operation))
        OpResponse: okpre_d = (chal != 64'd0) && (chal == cmd_q.challenge_value);
        OpConfirm:  okpre_d = validated_q[addr_q];
        OpAbandon:  cand_d  = (chal != 64'd0) & ~validated_q[addr_q];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      ent_vld_q   <= '0;
      validated_q <= '0;
      confirmed_q <= '0;
      active_q    <= 2'd0;
      cand_q      <= 1'b0;
      okpre_q     <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= in_rng & ent_vld_q[in_addr];
      end
      if (state_q == StExec) begin
        cand_q  <= cand_d;
        okpre_q <= okpre_d;
        if (rng_q) begin
          case (op_e'(cmd_q.operation))
            OpSend: begin
              ent_vld_q[addr_q] <= 1'b1;
            end
            OpResponse: begin
              if (okpre_d) begin
                validated_q[addr_q] <= 1'b1;
              end
            end
            OpConfirm: begin
              if (okpre_d) begin
                confirmed_q <= PATHS'(1) << addr_q;
                active_q    <= cmd_q.path_index;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign ok_now = okpre_q | (cand_q & (elapsed_q >= {30'd0, thr_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == StCmp);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StCmp) begin
      res_q <= '{ok: ok_now, active_path: active_q};
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == StIdle))
    else $error("result strobe while a command is in flight");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_q)
    else $error("result not delivered three cycles after accept");

  a_conf_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(confirmed_q))
    else $error("more than one path confirmed");

  a_conf_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (confirmed_q & ~validated_q) == '0)
    else $error("confirmed path is not validated");

endmodule
`default_nettype wire
